// ===== hw/rtl/tnaa_pkg.sv =====
// tnaa_pkg: widths, constants and sideband types of the triangle normal and area unit
// used by tnaa_sqrt, tnaa_div and triangle_normal_and_area_unit; no dependencies
package tnaa_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int TAG_W       = 20;
    localparam int NORM_W      = 32;
    localparam int AREA_W      = 48;
    localparam int AREA_SHIFT  = 17;

    localparam int DW  = COORD_WIDTH + 1;       // edge vector component
    localparam int PW  = 2 * DW;                // cross product partial
    localparam int WW  = PW + 1;                // cross product component
    localparam int MW  = PW;                    // cross product magnitude
    localparam int HW  = MW / 2;                // half of a magnitude
    localparam int SW  = 2 * MW;                // squared length
    localparam int LW  = MW;                    // length
    localparam int RW  = LW + 2;                // square root remainder
    localparam int QW  = 31;                    // quotient bits of a normal component
    localparam int DRW = LW + 1;                // divider remainder
    localparam int LXW = (LW > AREA_W + AREA_SHIFT) ? LW : AREA_W + AREA_SHIFT + 1;

    localparam int S_FIELDS_W = TAG_W + 9 * COORD_WIDTH;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = TAG_W + 3 * NORM_W + AREA_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [2:0]          neg;
        logic [2:0][MW-1:0]  mag;
        logic                degenerate;
    } sqrt_side_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [2:0]        neg;
        logic [AREA_W-1:0] area;
        logic              degenerate;
    } div_side_t;

endpackage

// ===== hw/rtl/tnaa_sqrt.sv =====
// tnaa_sqrt: pipelined integer square root, one result bit per stage
// depends on tnaa_pkg
module tnaa_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tnaa_pkg::SW-1:0]      in_rad,
    input  tnaa_pkg::sqrt_side_t         in_side,
    output logic                         out_valid,
    output logic [tnaa_pkg::LW-1:0]      out_root,
    output tnaa_pkg::sqrt_side_t         out_side
);

    localparam int N = tnaa_pkg::LW;

    logic                        valid_reg [N];
    logic [tnaa_pkg::SW-1:0]     rad_reg   [N];
    logic [tnaa_pkg::RW-1:0]     rem_reg   [N];
    logic [tnaa_pkg::LW-1:0]     root_reg  [N];
    tnaa_pkg::sqrt_side_t        side_reg  [N];

    logic                        valid_c [N+1];
    logic [tnaa_pkg::SW-1:0]     rad_c   [N+1];
    logic [tnaa_pkg::RW-1:0]     rem_c   [N+1];
    logic [tnaa_pkg::LW-1:0]     root_c  [N+1];
    tnaa_pkg::sqrt_side_t        side_c  [N+1];

    assign valid_c[0] = in_valid;
    assign rad_c[0]   = in_rad;
    assign rem_c[0]   = '0;
    assign root_c[0]  = '0;
    assign side_c[0]  = in_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [tnaa_pkg::RW-1:0] rem_sh;
        logic [tnaa_pkg::RW-1:0] trial;
        logic                    fits;
        logic [tnaa_pkg::RW-1:0] rem_next;
        logic [tnaa_pkg::LW-1:0] root_next;

        always_comb begin
            rem_sh    = {rem_c[k][tnaa_pkg::RW-3:0], rad_c[k][tnaa_pkg::SW-1 -: 2]};
            trial     = {root_c[k], 2'b01};
            fits      = (rem_sh >= trial);
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_c[k][tnaa_pkg::LW-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_c[k];
            end
            if (en) begin
                rad_reg[k]  <= {rad_c[k][tnaa_pkg::SW-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_c[k];
            end
        end

        assign valid_c[k+1] = valid_reg[k];
        assign rad_c[k+1]   = rad_reg[k];
        assign rem_c[k+1]   = rem_reg[k];
        assign root_c[k+1]  = root_reg[k];
        assign side_c[k+1]  = side_reg[k];
    end

    assign out_valid = valid_c[N];
    assign out_root  = root_c[N];
    assign out_side  = side_c[N];

endmodule

// ===== hw/rtl/tnaa_div.sv =====
// tnaa_div: three-lane pipelined restoring divider, floor(mag * 2^30 / len)
// depends on tnaa_pkg
module tnaa_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][tnaa_pkg::MW-1:0]        in_mag,
    input  logic [tnaa_pkg::LW-1:0]             in_len,
    input  tnaa_pkg::div_side_t                 in_side,
    output logic                                out_valid,
    output logic [2:0][tnaa_pkg::QW-1:0]        out_quot,
    output tnaa_pkg::div_side_t                 out_side
);

    localparam int N = tnaa_pkg::QW;

    logic                                 valid_reg [N];
    logic [2:0][tnaa_pkg::DRW-1:0]        rem_reg   [N];
    logic [2:0][tnaa_pkg::QW-1:0]         quot_reg  [N];
    logic [tnaa_pkg::LW-1:0]              len_reg   [N];
    tnaa_pkg::div_side_t                  side_reg  [N];

    logic                                 valid_c [N+1];
    logic [2:0][tnaa_pkg::DRW-1:0]        rem_c   [N+1];
    logic [2:0][tnaa_pkg::QW-1:0]         quot_c  [N+1];
    logic [tnaa_pkg::LW-1:0]              len_c   [N+1];
    tnaa_pkg::div_side_t                  side_c  [N+1];

    assign valid_c[0] = in_valid;
    assign len_c[0]   = in_len;
    assign side_c[0]  = in_side;
    assign quot_c[0]  = '0;
    for (genvar j = 0; j < 3; j++) begin : g_init
        assign rem_c[0][j] = {1'b0, in_mag[j]};
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [2:0][tnaa_pkg::DRW-1:0] rem_next;
        logic [2:0][tnaa_pkg::QW-1:0]  quot_next;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                logic [tnaa_pkg::DRW-1:0] r_sh;
                logic                     ge;
                // first stage holds the integer bit, the rest shift in a zero
                r_sh = (k == 0) ? rem_c[k][j] : {rem_c[k][j][tnaa_pkg::DRW-2:0], 1'b0};
                ge   = (r_sh >= {1'b0, len_c[k]});
                rem_next[j]  = ge ? (r_sh - {1'b0, len_c[k]}) : r_sh;
                quot_next[j] = {quot_c[k][j][tnaa_pkg::QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_c[k];
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                len_reg[k]  <= len_c[k];
                side_reg[k] <= side_c[k];
            end
        end

        assign valid_c[k+1] = valid_reg[k];
        assign rem_c[k+1]   = rem_reg[k];
        assign quot_c[k+1]  = quot_reg[k];
        assign len_c[k+1]   = len_reg[k];
        assign side_c[k+1]  = side_reg[k];
    end

    assign out_valid = valid_c[N];
    assign out_quot  = quot_c[N];
    assign out_side  = side_c[N];

endmodule

// ===== hw/rtl/triangle_normal_and_area_unit.sv =====
// triangle_normal_and_area_unit: unit normal and area of one mesh face per transfer
// depends on tnaa_pkg, tnaa_sqrt and tnaa_div

// One face enters per clock cycle while the pipeline moves. It passes through seven
// front stages (edges, cross products, magnitude, squared length), 66 stages of the
// square root (one length bit each), 31 stages of the three parallel dividers and
// the output register. The whole pipeline moves as one; it halts only while a result
// sits in the output register and m_tready is low. Degenerate faces (zero cross
// product) give a zero normal, zero area and the degenerate flag. The area saturates
// at all ones when the length shifted right by 17 bits does not fit 48 bits.
module triangle_normal_and_area_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // face_tag, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
    // vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, zero fill
    input  logic [tnaa_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // face_tag_out, normal_x, normal_y, normal_z, face_area, degenerate, zero fill
    output logic [tnaa_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int CW = tnaa_pkg::COORD_WIDTH;
    localparam int DW = tnaa_pkg::DW;
    localparam int PW = tnaa_pkg::PW;
    localparam int WW = tnaa_pkg::WW;
    localparam int MW = tnaa_pkg::MW;
    localparam int HW = tnaa_pkg::HW;
    localparam int SW = tnaa_pkg::SW;
    localparam int TW = tnaa_pkg::TAG_W;

    logic adv;
    logic m_valid_reg;
    logic [tnaa_pkg::M_DATA_W-1:0] m_data_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: edge vectors
    logic                         v1_reg;
    logic [TW-1:0]                tag1_reg;
    logic signed [DW-1:0]         u1_reg [3];
    logic signed [DW-1:0]         e1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
        if (adv) begin
            tag1_reg <= s_tdata[TW-1:0];
            for (int j = 0; j < 3; j++) begin
                u1_reg[j] <= DW'($signed(s_tdata[TW + j*CW +: CW]))
                           - DW'($signed(s_tdata[TW + (3+j)*CW +: CW]));
                e1_reg[j] <= DW'($signed(s_tdata[TW + (6+j)*CW +: CW]))
                           - DW'($signed(s_tdata[TW + (3+j)*CW +: CW]));
            end
        end
    end

    // ---------------- stage 2: cross product partials
    logic                         v2_reg;
    logic [TW-1:0]                tag2_reg;
    logic signed [PW-1:0]         pa2_reg [3];
    logic signed [PW-1:0]         pb2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            tag2_reg <= tag1_reg;
            for (int j = 0; j < 3; j++) begin
                pa2_reg[j] <= PW'(u1_reg[(j+1)%3]) * PW'(e1_reg[(j+2)%3]);
                pb2_reg[j] <= PW'(u1_reg[(j+2)%3]) * PW'(e1_reg[(j+1)%3]);
            end
        end
    end

    // ---------------- stage 3: cross product
    logic                         v3_reg;
    logic [TW-1:0]                tag3_reg;
    logic signed [WW-1:0]         w3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            tag3_reg <= tag2_reg;
            for (int j = 0; j < 3; j++) begin
                w3_reg[j] <= WW'(pa2_reg[j]) - WW'(pb2_reg[j]);
            end
        end
    end

    // ---------------- stage 4: sign and magnitude
    logic                         v4_reg;
    logic [TW-1:0]                tag4_reg;
    logic [2:0]                   neg4_reg;
    logic [2:0][MW-1:0]           mag4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
        if (adv) begin
            tag4_reg <= tag3_reg;
            for (int j = 0; j < 3; j++) begin
                neg4_reg[j] <= w3_reg[j][WW-1];
                mag4_reg[j] <= w3_reg[j][WW-1] ? MW'(-w3_reg[j]) : MW'(w3_reg[j]);
            end
        end
    end

    // ---------------- stage 5: half-word products of the squares
    logic                         v5_reg;
    tnaa_pkg::sqrt_side_t         side5_reg;
    logic [2*HW-1:0]              hh5_reg [3];
    logic [2*HW-1:0]              hl5_reg [3];
    logic [2*HW-1:0]              ll5_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
        if (adv) begin
            side5_reg.tag        <= tag4_reg;
            side5_reg.neg        <= neg4_reg;
            side5_reg.mag        <= mag4_reg;
            side5_reg.degenerate <= (mag4_reg == '0);
            for (int j = 0; j < 3; j++) begin
                hh5_reg[j] <= (2*HW)'(mag4_reg[j][MW-1 -: HW]) * (2*HW)'(mag4_reg[j][MW-1 -: HW]);
                hl5_reg[j] <= (2*HW)'(mag4_reg[j][MW-1 -: HW]) * (2*HW)'(mag4_reg[j][HW-1:0]);
                ll5_reg[j] <= (2*HW)'(mag4_reg[j][HW-1:0]) * (2*HW)'(mag4_reg[j][HW-1:0]);
            end
        end
    end

    // ---------------- stage 6: squares
    logic                         v6_reg;
    tnaa_pkg::sqrt_side_t         side6_reg;
    logic [SW-1:0]                sq6_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v5_reg;
        end
        if (adv) begin
            side6_reg <= side5_reg;
            for (int j = 0; j < 3; j++) begin
                sq6_reg[j] <= (SW'(hh5_reg[j]) << MW) + (SW'(hl5_reg[j]) << (HW + 1))
                            + SW'(ll5_reg[j]);
            end
        end
    end

    // ---------------- stage 7: squared length
    logic                         v7_reg;
    tnaa_pkg::sqrt_side_t         side7_reg;
    logic [SW-1:0]                s7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (adv) begin
            v7_reg <= v6_reg;
        end
        if (adv) begin
            side7_reg <= side6_reg;
            s7_reg    <= sq6_reg[0] + sq6_reg[1] + sq6_reg[2];
        end
    end

    // ---------------- square root
    logic                         sq_valid;
    logic [tnaa_pkg::LW-1:0]      sq_root;
    tnaa_pkg::sqrt_side_t         sq_side;

    tnaa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v7_reg),
        .in_rad    (s7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // area from the length, saturating
    logic [tnaa_pkg::LXW-1:0]     len_x;
    tnaa_pkg::div_side_t          dv_side_in;

    always_comb begin
        len_x                 = tnaa_pkg::LXW'(sq_root);
        dv_side_in.tag        = sq_side.tag;
        dv_side_in.neg        = sq_side.neg;
        dv_side_in.degenerate = sq_side.degenerate;
        if (len_x[tnaa_pkg::LXW-1:tnaa_pkg::AREA_W + tnaa_pkg::AREA_SHIFT] != '0) begin
            dv_side_in.area = '1;
        end else begin
            dv_side_in.area = len_x[tnaa_pkg::AREA_SHIFT +: tnaa_pkg::AREA_W];
        end
    end

    // ---------------- normal components
    logic                               dv_valid;
    logic [2:0][tnaa_pkg::QW-1:0]       dv_quot;
    tnaa_pkg::div_side_t                dv_side;

    tnaa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_mag    (sq_side.mag),
        .in_len    (sq_root),
        .in_side   (dv_side_in),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // ---------------- output register
    logic [2:0][tnaa_pkg::NORM_W-1:0]   norm;
    logic [tnaa_pkg::M_DATA_W-1:0]      m_data_next;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (dv_side.degenerate) begin
                norm[j] = '0;
            end else if (dv_side.neg[j]) begin
                norm[j] = -tnaa_pkg::NORM_W'(dv_quot[j]);
            end else begin
                norm[j] = tnaa_pkg::NORM_W'(dv_quot[j]);
            end
        end
        m_data_next = tnaa_pkg::M_DATA_W'({
            dv_side.degenerate,
            dv_side.degenerate ? {tnaa_pkg::AREA_W{1'b0}} : dv_side.area,
            norm[2], norm[1], norm[0],
            dv_side.tag
        });
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    localparam int NX_LSB = TW;
    localparam int DEG_BIT = TW + 3 * tnaa_pkg::NORM_W + tnaa_pkg::AREA_W;

    // a degenerate face carries neither normal nor area
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DEG_BIT] |-> m_tdata[DEG_BIT-1:NX_LSB] == '0)
        else $error("degenerate face with nonzero normal or area");

    // a held result stalls the whole pipeline, input side included
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // the normal x component stays within plus or minus one
    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[NX_LSB +: tnaa_pkg::NORM_W]) <= 32'sh4000_0000
                   && $signed(m_tdata[NX_LSB +: tnaa_pkg::NORM_W]) >= -32'sh4000_0000))
        else $error("normal x component out of range");
`endif

endmodule

// ===== sim/tb_triangle_normal_and_area_unit.sv =====
// tb_triangle_normal_and_area_unit: self-checking bench for the triangle normal and area unit
// depends on tnaa_pkg and triangle_normal_and_area_unit; drives faces, predicts normal and area
module tb_triangle_normal_and_area_unit;

    localparam int LIMIT = 400000;
    localparam int N_RANDOM = 540;

    typedef struct packed {
        logic                        degenerate;
        logic [tnaa_pkg::AREA_W-1:0] area;
        logic [31:0]                 nz;
        logic [31:0]                 ny;
        logic [31:0]                 nx;
        logic [tnaa_pkg::TAG_W-1:0]  tag;
    } face_result_t;

    typedef struct {
        logic [tnaa_pkg::TAG_W-1:0]       tag;
        logic [tnaa_pkg::COORD_WIDTH-1:0] v[9];
    } face_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [tnaa_pkg::S_DATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [tnaa_pkg::M_DATA_W-1:0] m_tdata;

    face_result_t expected_results[$];
    int  fail_count;
    int  cycle_count;
    bit  stimulus_done;
    bit  hold_off;

    triangle_normal_and_area_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // integer square root, bit by bit
    function automatic logic [255:0] isqrt(logic [255:0] s);
        logic [255:0] r;
        logic [255:0] t;
        r = '0;
        for (int b = 127; b >= 0; b--) begin
            t = r | (256'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic face_result_t face_normal_area(face_t f);
        face_result_t     r;
        logic signed [255:0] p[9];
        logic signed [255:0] u[3];
        logic signed [255:0] v[3];
        logic signed [255:0] w[3];
        logic [255:0]     mag[3];
        logic [255:0]     s;
        logic [255:0]     len;
        logic [255:0]     q;
        logic [31:0]      comp[3];
        for (int i = 0; i < 9; i++)
            p[i] = {{(256-tnaa_pkg::COORD_WIDTH){f.v[i][tnaa_pkg::COORD_WIDTH-1]}}, f.v[i]};
        for (int j = 0; j < 3; j++) begin
            u[j] = p[j] - p[3+j];
            v[j] = p[6+j] - p[3+j];
        end
        for (int j = 0; j < 3; j++)
            w[j] = u[(j+1)%3] * v[(j+2)%3] - u[(j+2)%3] * v[(j+1)%3];
        s = '0;
        for (int j = 0; j < 3; j++) begin
            mag[j] = w[j] < 0 ? -w[j] : w[j];
            s = s + mag[j] * mag[j];
        end
        r.tag = f.tag;
        if (s == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.area = '0; r.degenerate = 1'b1;
            return r;
        end
        len = isqrt(s);
        for (int j = 0; j < 3; j++) begin
            q = (mag[j] << 30) / len;
            comp[j] = w[j] < 0 ? 32'(-q) : 32'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
        r.area = (len >> tnaa_pkg::AREA_SHIFT) > 256'hFFFF_FFFF_FFFF ? '1
               : tnaa_pkg::AREA_W'(len >> tnaa_pkg::AREA_SHIFT);
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic logic [tnaa_pkg::S_DATA_W-1:0] pack_face(face_t f);
        logic [tnaa_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[tnaa_pkg::TAG_W-1:0] = f.tag;
        for (int i = 0; i < 9; i++)
            d[tnaa_pkg::TAG_W + i*tnaa_pkg::COORD_WIDTH +: tnaa_pkg::COORD_WIDTH] = f.v[i];
        return d;
    endfunction

    function automatic logic [tnaa_pkg::COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? {1'b1, {(tnaa_pkg::COORD_WIDTH-1){1'b0}}}
                                          : {1'b0, {(tnaa_pkg::COORD_WIDTH-1){1'b1}}};
            1: return tnaa_pkg::COORD_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
            2: return tnaa_pkg::COORD_WIDTH'($signed($urandom_range(0, 32'h0004_0000))
                                             - 32'h0002_0000);
            default: return tnaa_pkg::COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic face_t rand_face();
        face_t f;
        int kind;
        f.tag = tnaa_pkg::TAG_W'($urandom);
        for (int i = 0; i < 9; i++)
            f.v[i] = rand_coord();
        kind = $urandom_range(0, 9);
        // collinear or coincident vertices to hit the degenerate path
        if (kind == 0) begin
            for (int j = 0; j < 3; j++)
                f.v[j] = f.v[3+j];
        end else if (kind == 1) begin
            for (int j = 0; j < 3; j++)
                f.v[6+j] = f.v[3+j] + (f.v[j] - f.v[3+j]) * 2;
        end
        return f;
    endfunction

    // drops tvalid only when a real gap follows
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic send_face(face_t f, bit typed, face_result_t typed_result);
        face_result_t e;
        if (typed)
            e = typed_result;
        else
            e = face_normal_area(f);
        s_tdata  <= pack_face(f);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.insert(expected_results.size(), e);
        @(negedge aclk);
    endtask

    // directed faces; expected result typed in where it is obvious
    task automatic run_directed();
        face_t        f;
        face_result_t e;
        logic [tnaa_pkg::COORD_WIDTH-1:0] mx;
        logic [tnaa_pkg::COORD_WIDTH-1:0] mn;
        mx = {1'b0, {(tnaa_pkg::COORD_WIDTH-1){1'b1}}};
        mn = {1'b1, {(tnaa_pkg::COORD_WIDTH-1){1'b0}}};
        for (int row = 0; row < 12; row++) begin
            f.tag = tnaa_pkg::TAG_W'(row);
            for (int i = 0; i < 9; i++) f.v[i] = '0;
            e = '0;
            case (row)
                0: begin
                    f.tag = '1; e.tag = '1; e.degenerate = 1'b1;
                end
                1: begin
                    // unit right triangle in xy plane: normal +z, area 0.5
                    f.v[0] = 32'h0001_0000; f.v[7] = 32'h0001_0000;
                    e.tag = tnaa_pkg::TAG_W'(1); e.nz = 32'sd1 << 30; e.area = 48'h8000;
                end
                2: begin
                    f.v[7] = 32'h0001_0000; f.v[0] = 32'h0001_0000;
                    f.v[6] = 32'h0001_0000; f.v[7] = 32'h0; f.v[1] = 32'h0001_0000;
                    f.v[0] = 32'h0;
                    e.tag = tnaa_pkg::TAG_W'(2); e.nz = -(32'sd1 << 30); e.area = 48'h8000;
                end
                3: begin
                    for (int i = 0; i < 9; i++) f.v[i] = mx;
                    e.tag = tnaa_pkg::TAG_W'(3); e.degenerate = 1'b1;
                end
                4: begin
                    f.v[0] = mx; f.v[4] = mx; f.v[8] = mx;
                end
                5: begin
                    f.v[0] = mx; f.v[1] = mn; f.v[2] = mx;
                    f.v[3] = mn; f.v[4] = mx; f.v[5] = mn;
                    f.v[6] = mx; f.v[7] = mx; f.v[8] = mn;
                end
                6: begin
                    // widest spread across the coordinate cube
                    f.v[0] = mx; f.v[3] = mn; f.v[4] = mn; f.v[5] = mn;
                    f.v[7] = mx; f.v[8] = mx; f.v[1] = mn; f.v[2] = mx; f.v[6] = mn;
                end
                7: begin
                    f.v[0] = 32'h1; f.v[7] = 32'h1;
                end
                8: begin
                    f.v[1] = 32'h3; f.v[2] = 32'h5; f.v[8] = 32'hFFFF_FFF9;
                end
                9: begin
                    for (int i = 0; i < 9; i++) f.v[i] = 32'hAAAA_5555 ^ (i * 32'h0101_0101);
                end
                10: begin
                    for (int i = 0; i < 9; i++) f.v[i] = 32'h5555_AAAA + i * 32'h1234_5678;
                end
                default: begin
                    f.tag = 20'h5A5A5;
                    f.v[3] = mn; f.v[4] = mn; f.v[5] = mn;
                    f.v[0] = mn; f.v[1] = mn; f.v[2] = mn;
                    e.tag = 20'h5A5A5; e.degenerate = 1'b1;
                end
            endcase
            send_face(f, row <= 3 || row == 11, e);
            idle_gap();
        end
    endtask

    initial begin
        face_result_t none;
        fail_count    = 0;
        stimulus_done = 1'b0;
        hold_off      = 1'b0;
        none          = '0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run_directed();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_off = 1'b1;
            send_face(rand_face(), 1'b0, none);
            if (n < 150 || n > 330) idle_gap();
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off so the pipeline fills
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            if ($urandom_range(0, 19) == 0)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 3) != 0)
                m_tready <= 1'b1;
            else
                m_tready <= 1'($urandom_range(0, 1));
        end
    end

    always @(posedge aclk) begin
        face_result_t got;
        face_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got = face_result_t'(m_tdata[tnaa_pkg::M_FIELDS_W-1:0]);
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", got);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (got.tag != e.tag) begin
                    $error("face_tag_out exp %h got %h", e.tag, got.tag); fail_count++;
                end
                if (got.nx != e.nx) begin
                    $error("normal_x exp %h got %h", e.nx, got.nx); fail_count++;
                end
                if (got.ny != e.ny) begin
                    $error("normal_y exp %h got %h", e.ny, got.ny); fail_count++;
                end
                if (got.nz != e.nz) begin
                    $error("normal_z exp %h got %h", e.nz, got.nz); fail_count++;
                end
                if (got.area != e.area) begin
                    $error("face_area exp %h got %h", e.area, got.area); fail_count++;
                end
                if (got.degenerate != e.degenerate) begin
                    $error("degenerate exp %b got %b", e.degenerate, got.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
